// ----- design/assert_macros.svh -----
// assertion macros shared by the tlv parser modules
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ATLV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// expression must never be true outside reset
`define ATLV_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ----- design/atlv_pkg.sv -----
// types, codes and tables for the application-parameter tlv parser
// no dependencies
package atlv_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_BADTAG   = 2'd3;

    // parameter ids
    localparam logic [2:0] ID_STATUS     = 3'd0;
    localparam logic [2:0] ID_ORDER      = 3'd1;
    localparam logic [2:0] ID_SEARCH     = 3'd2;
    localparam logic [2:0] ID_SEARCH_ATT = 3'd3;
    localparam logic [2:0] ID_MAX_COUNT  = 3'd4;
    localparam logic [2:0] ID_START_OFS  = 3'd5;
    localparam logic [2:0] ID_FILTER     = 3'd6;
    localparam logic [2:0] ID_FORMAT     = 3'd7;

    // record tags
    localparam logic [7:0] TAG_SEARCH = 8'h02;
    localparam logic [7:0] TAG_MIN    = 8'h01;
    localparam logic [7:0] TAG_MAX    = 8'h07;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // one queue entry: an optional parameter result and an optional end-of-header result
    typedef struct packed {
        logic        has_data;
        logic [2:0]  param_id;
        logic [63:0] param_value;
        logic        search_last;
        logic        search_empty;
        logic        has_done;
        logic [1:0]  status;
    } atlv_entry_t;

    // expected value length per known tag, search value takes any length
    function automatic logic [7:0] expect_len(input logic [2:0] id);
        logic [7:0] r;
        case (id)
            ID_ORDER:      r = 8'd1;
            ID_SEARCH_ATT: r = 8'd1;
            ID_MAX_COUNT:  r = 8'd2;
            ID_START_OFS:  r = 8'd2;
            ID_FILTER:     r = 8'd8;
            ID_FORMAT:     r = 8'd1;
            default:       r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/atlv_front.sv -----
// front end: accepts start items and payload bytes, walks the tlv records
// depends on atlv_pkg and assert_macros.svh
`include "assert_macros.svh"

module atlv_front import atlv_pkg::*; #(
    parameter int LEN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        q_full,
    output logic        q_push,
    output atlv_entry_t q_entry
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TAG   = 2'd1;
    localparam logic [1:0] PH_LEN   = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;
    localparam int HW = (LEN_BITS > 16) ? LEN_BITS : 16;

    logic [1:0]          phase_reg, phase_next;
    logic [LEN_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]          record_tag_reg, record_tag_next;
    logic [7:0]          record_len_reg, record_len_next;
    logic [7:0]          value_count_reg, value_count_next;
    logic [63:0]         value_accum_reg, value_accum_next;

    logic                accept;
    logic [HW-1:0]       hdr_ext;
    logic [LEN_BITS-1:0] start_len;
    logic [LEN_BITS-1:0] bl_dec;
    logic [7:0]          data_b;
    logic                rec_end;
    atlv_entry_t         ent;

    assign accept    = s_tvalid && !q_full;
    assign s_tready  = !q_full;
    assign data_b    = s_tdata[23:16];
    assign hdr_ext   = HW'(s_tdata[15:0]);
    assign start_len = hdr_ext[LEN_BITS-1:0];
    assign bl_dec    = bytes_left_reg - LEN_BITS'(1);

    // record parser
    always_comb begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        record_tag_next  = record_tag_reg;
        record_len_next  = record_len_reg;
        value_count_next = value_count_reg;
        value_accum_next = value_accum_reg;
        ent              = '0;
        rec_end          = 1'b0;
        if (accept) begin
            if (!s_tuser) begin
                // start of a header
                bytes_left_next  = start_len;
                record_tag_next  = '0;
                record_len_next  = '0;
                value_count_next = '0;
                value_accum_next = '0;
                if (start_len < LEN_BITS'(2)) begin
                    ent.has_done = 1'b1;
                    ent.status   = ST_SHORT;
                    phase_next   = PH_IDLE;
                end else if (start_len == LEN_BITS'(2)) begin
                    ent.has_done = 1'b1;
                    ent.status   = ST_OK;
                    phase_next   = PH_IDLE;
                end else begin
                    phase_next = PH_TAG;
                end
            end else begin
                case (phase_reg)
                    PH_TAG: begin
                        record_tag_next = data_b;
                        bytes_left_next = bl_dec;
                        phase_next      = PH_LEN;
                    end
                    PH_LEN: begin
                        record_len_next  = data_b;
                        bytes_left_next  = bl_dec;
                        value_count_next = '0;
                        value_accum_next = '0;
                        if (LEN_BITS'(data_b) > bl_dec) begin
                            ent.has_done = 1'b1;
                            ent.status   = ST_OVERFLOW;
                            phase_next   = PH_IDLE;
                        end else if (record_tag_reg < TAG_MIN || record_tag_reg > TAG_MAX) begin
                            ent.has_done = 1'b1;
                            ent.status   = ST_BADTAG;
                            phase_next   = PH_IDLE;
                        end else if (data_b == 8'd0) begin
                            if (record_tag_reg == TAG_SEARCH) begin
                                ent.has_data     = 1'b1;
                                ent.param_id     = ID_SEARCH;
                                ent.search_empty = 1'b1;
                            end
                            rec_end = 1'b1;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (bytes_left_reg != '0) begin
                            bytes_left_next = bl_dec;
                        end
                        value_count_next = value_count_reg + 8'd1;
                        value_accum_next = {value_accum_reg[55:0], data_b};
                        rec_end          = (value_count_next == record_len_reg);
                        if (record_tag_reg == TAG_SEARCH) begin
                            ent.has_data    = 1'b1;
                            ent.param_id    = ID_SEARCH;
                            ent.param_value = {56'd0, data_b};
                            ent.search_last = rec_end;
                        end else if (rec_end &&
                                     record_len_reg == expect_len(record_tag_reg[2:0])) begin
                            ent.has_data    = 1'b1;
                            ent.param_id    = record_tag_reg[2:0];
                            ent.param_value = value_accum_next;
                        end
                    end
                    default: begin
                        // bytes outside an open header are dropped
                    end
                endcase
                // record boundary: end the header when too few bytes remain
                if (rec_end) begin
                    if (bytes_left_next <= LEN_BITS'(2)) begin
                        ent.has_done = 1'b1;
                        ent.status   = ST_OK;
                        phase_next   = PH_IDLE;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end
            end
        end
    end

    assign q_push  = accept && (ent.has_data || ent.has_done);
    assign q_entry = ent;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            bytes_left_reg  <= '0;
            record_tag_reg  <= '0;
            record_len_reg  <= '0;
            value_count_reg <= '0;
            value_accum_reg <= '0;
        end else begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            record_tag_reg  <= record_tag_next;
            record_len_reg  <= record_len_next;
            value_count_reg <= value_count_next;
            value_accum_reg <= value_accum_next;
        end
    end

    `ATLV_ASSERT(a_value_len, phase_reg == PH_VALUE |-> record_len_reg != 8'd0, "value phase with zero length")
    `ATLV_ASSERT(a_done_idle, q_push && q_entry.has_done |=> phase_reg == PH_IDLE, "header ended but parser not idle")

endmodule

// ----- design/atlv_queue.sv -----
// short result queue between the parser and the output stage
// depends on atlv_pkg and assert_macros.svh
`include "assert_macros.svh"

module atlv_queue import atlv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  atlv_entry_t push_entry,
    output logic        full,
    output logic        head_valid,
    output atlv_entry_t head_entry,
    input  logic        pop
);

    atlv_entry_t     mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ATLV_NEVER(a_push_full, push && full, "push into full queue")
    `ATLV_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")

endmodule

// ----- design/atlv_back.sv -----
// back end: splits queue entries into result beats behind an output register
// depends on atlv_pkg and assert_macros.svh
`include "assert_macros.svh"

module atlv_back import atlv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  atlv_entry_t head_entry,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic        part_reg, part_next;
    logic [2:0]  id_reg, id_next;
    logic [63:0] value_reg, value_next;
    logic        slast_reg, slast_next;
    logic        sempty_reg, sempty_next;
    logic [1:0]  status_reg, status_next;
    logic        done_reg, done_next;
    logic        last_reg, last_next;
    logic        load;
    logic        data_beat;

    assign load      = !valid_reg || m_tready;
    assign data_beat = head_entry.has_data && !part_reg;

    // next beat from the queue head
    always_comb begin
        valid_next  = valid_reg;
        part_next   = part_reg;
        id_next     = id_reg;
        value_next  = value_reg;
        slast_next  = slast_reg;
        sempty_next = sempty_reg;
        status_next = status_reg;
        done_next   = done_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (data_beat) begin
                    id_next     = head_entry.param_id;
                    value_next  = head_entry.param_value;
                    slast_next  = head_entry.search_last;
                    sempty_next = head_entry.search_empty;
                    status_next = ST_OK;
                    done_next   = 1'b0;
                    last_next   = !head_entry.has_done;
                    pop         = !head_entry.has_done;
                    part_next   = head_entry.has_done;
                end else begin
                    id_next     = ID_STATUS;
                    value_next  = '0;
                    slast_next  = 1'b0;
                    sempty_next = 1'b0;
                    status_next = head_entry.status;
                    done_next   = 1'b1;
                    last_next   = 1'b1;
                    pop         = 1'b1;
                    part_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            part_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            part_reg  <= part_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        value_reg  <= value_next;
        slast_reg  <= slast_next;
        sempty_reg <= sempty_next;
        status_reg <= status_next;
        done_reg   <= done_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = id_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'd0, done_reg, status_reg, sempty_reg, slast_reg, value_reg};

    `ATLV_ASSERT(a_done_last, valid_reg && done_reg |-> last_reg, "end-of-header result not last")
    `ATLV_ASSERT(a_part_head, part_reg |-> head_valid && head_entry.has_done, "split entry lost")

endmodule

// ----- design/app_param_tlv_parser.sv -----
// top level of the application-parameter tlv parser
// depends on atlv_pkg, atlv_front, atlv_queue and atlv_back
//
//  channel | direction | tdata (low bit up)                     | tuser    | tlast
//  s_      | in        | header_len[15:0], data_byte[23:16]     | func     | -
//  m_      | out       | param_value[63:0], search_last,        | param_id | last
//          |           | search_empty, status[1:0], header_done |          |
//
//  one request is taken per cycle while the queue is not full; the parser state is registered
//  a request that ends a record with both a parameter and an end-of-header result
//  yields a parameter beat, then an end-of-header beat; a four-entry queue lets the
//  parser run ahead of the output; results pass the queue storage and the m_ register
//  reset is synchronous and clears control state only; no clearing pass
//  s_tready drops only while the queue is full

module app_param_tlv_parser import atlv_pkg::*; #(
    parameter int LEN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // header_len[15:0], data_byte[23:16]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // param_value[63:0], search_last[64], search_empty[65],
                                   // status[67:66], header_done[68], zero pad
    output logic [2:0]  m_tuser,   // param_id
    output logic        m_tlast
);

    logic        q_push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    atlv_entry_t q_in;
    atlv_entry_t q_head;

    // record parser
    atlv_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // result queue
    atlv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    // output stage
    atlv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
